@@ rtl/core/cpoc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpoc_pkg
// shared constants and codes of the chain partial order closure block
// ----------------------------------------------------------------------------
package cpoc_pkg;

  localparam int NUM_LINES       = 8;
  localparam int EVENTS_PER_LINE = 64;

  typedef enum logic [2:0] {
    OP_ADD_LINE  = 3'd0,
    OP_APPEND    = 3'd1,
    OP_ADD_EDGE  = 3'd2,
    OP_ORDER     = 3'd3,
    OP_SAFE      = 3'd4,
    OP_SUCC      = 3'd5,
    OP_PRED      = 3'd6,
    OP_MARK_SAFE = 3'd7
  } opcode_e;

  // which step of edge closure called the pair insertion
  typedef enum logic [1:0] {
    PH_MAIN = 2'd0,
    PH_BEF  = 2'd1,
    PH_AFT  = 2'd2,
    PH_PAIR = 2'd3
  } phase_e;

endpackage

@@ rtl/core/cpoc_ram.sv @@
// ----------------------------------------------------------------------------
// cpoc_ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module cpoc_ram #(
  parameter int DATA_W = 7,
  parameter int ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/chain_partial_order_closure.sv @@
// ----------------------------------------------------------------------------
// chain_partial_order_closure
// incremental happens-before closure over events kept on a set of lines
// ----------------------------------------------------------------------------
// One request on the input channel gives exactly one result on the output
// channel. A request is taken only when the block is idle; the block keeps
// working on it alone until the result is in the output register.
// Work per request, from accept to result valid:
//   safe query, mark safe, requests rejected at decode: decode only
//   order, successor, predecessor queries: reads of the clock memories
//   append event: a read and a write-back for each other active line
//   add line: a sweep over each existing line and each event on those lines
//   add edge: neighbour collection over each active line, then for each
//     inserted pair a bound update over each active line, the clock entries
//     rewritten on the two walks, plus the scan over line pairs
// All clock state lives in two single-port-read memories (successor and
// predecessor clocks); each step reads one entry, uses the registered read
// data and writes back where needed.
// A result waits in the output register while the receiver stalls; the next
// request can still be taken and worked on, and its result is held back until
// the first is taken. Reset empties the block: no lines, no events, all
// bounds zero. Memory contents are not cleared; entries are written before
// they are read.
// ----------------------------------------------------------------------------
module chain_partial_order_closure #(
  parameter int NUM_LINES       = cpoc_pkg::NUM_LINES,
  parameter int EVENTS_PER_LINE = cpoc_pkg::EVENTS_PER_LINE,
  localparam int LW = $clog2(NUM_LINES),
  localparam int IW = $clog2(EVENTS_PER_LINE),
  localparam int CW = $clog2(EVENTS_PER_LINE + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    opcode_i,
  input  logic [LW-1:0] from_line_i,
  input  logic [IW-1:0] from_index_i,
  input  logic [LW-1:0] to_line_i,
  input  logic [IW-1:0] to_index_i,
  input  logic          to_is_atomic_write_i,
  input  logic          from_writes_atomically_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          status_o,
  output logic          holds_forward_o,
  output logic          holds_backward_o,
  output logic          is_safe_o,
  output logic          clock_found_o,
  output logic [IW-1:0] clock_index_o,
  output logic [CW-1:0] line_length_o
);

  localparam int AW = $clog2(NUM_LINES + 1);
  localparam int MW = 2 * LW + IW;
  localparam logic [CW-1:0] NONE_SUCC = CW'(EVENTS_PER_LINE);
  localparam int NS = 25;

  typedef enum logic [NS-1:0] {
    ST_IDLE      = NS'(1) << 0,
    ST_DECODE    = NS'(1) << 1,
    ST_SWEEP     = NS'(1) << 2,
    ST_APP_RD    = NS'(1) << 3,
    ST_APP_USE   = NS'(1) << 4,
    ST_QA        = NS'(1) << 5,
    ST_QB        = NS'(1) << 6,
    ST_QEVAL     = NS'(1) << 7,
    ST_COL_RD    = NS'(1) << 8,
    ST_COL_USE   = NS'(1) << 9,
    ST_IP_LB_RD  = NS'(1) << 10,
    ST_IP_LB_USE = NS'(1) << 11,
    ST_IP_WR     = NS'(1) << 12,
    ST_IP_SW_RD  = NS'(1) << 13,
    ST_IP_SW_USE = NS'(1) << 14,
    ST_IP_PW_RD  = NS'(1) << 15,
    ST_IP_PW_USE = NS'(1) << 16,
    ST_IP_RET    = NS'(1) << 17,
    ST_BF_CHK    = NS'(1) << 18,
    ST_BF_USE    = NS'(1) << 19,
    ST_AF_CHK    = NS'(1) << 20,
    ST_AF_USE    = NS'(1) << 21,
    ST_PR_CHK    = NS'(1) << 22,
    ST_PR_USE    = NS'(1) << 23,
    ST_DONE      = NS'(1) << 24
  } state_e;

  state_e state_q, state_d;
  cpoc_pkg::opcode_e op_q, op_d;
  cpoc_pkg::phase_e phase_q, phase_d;

  logic [LW-1:0] fl_q, fl_d, tl_q, tl_d;
  logic [IW-1:0] fi_q, fi_d, ti_q, ti_d;
  logic          to_at_q, to_at_d, from_at_q, from_at_d;
  logic [CW-1:0] len_f_q, len_f_d;
  logic [AW-1:0] active_q, active_d;
  logic [CW-1:0] len_q [NUM_LINES];
  logic [CW-1:0] len_d [NUM_LINES];
  logic [CW-1:0] sb_q [NUM_LINES];
  logic [CW-1:0] sb_d [NUM_LINES];
  logic [NUM_LINES-1:0] has_bef_q, has_bef_d, has_aft_q, has_aft_d;
  logic [IW-1:0] bef_q [NUM_LINES];
  logic [IW-1:0] bef_d [NUM_LINES];
  logic [IW-1:0] aft_q [NUM_LINES];
  logic [IW-1:0] aft_d [NUM_LINES];
  logic [AW-1:0] ok_q, ok_d, om_q, om_d, ik_q, ik_d;
  logic [CW-1:0] w_q, w_d;
  logic [LW-1:0] p_q, p_d, q_q, q_d;
  logic [IW-1:0] x_q, x_d, y_q, y_d;

  logic          res_status_q, res_status_d, res_fwd_q, res_fwd_d, res_bwd_q, res_bwd_d;
  logic          res_safe_q, res_safe_d, res_found_q, res_found_d;
  logic [IW-1:0] res_cidx_q, res_cidx_d;

  logic          out_valid_q, out_valid_d;
  logic          status_q, status_d, fwd_q, fwd_d, bwd_q, bwd_d;
  logic          safe_q, safe_d, found_q, found_d;
  logic [IW-1:0] cidx_q, cidx_d;
  logic [CW-1:0] len_out_q, len_out_d;

  logic          s_we, p_we;
  logic [MW-1:0] s_waddr, s_raddr, p_waddr, p_raddr;
  logic [CW-1:0] s_wdata, p_wdata, s_rdata, p_rdata;

  logic [LW-1:0] len_idx;
  logic [CW-1:0] len_sel;
  logic [LW-1:0] aft_idx;
  logic [IW-1:0] bef_sel, aft_sel;
  logic          has_bef_sel, has_aft_sel;
  logic          fl_act, tl_act, f_ok, t_ok;
  logic [CW-1:0] pm1, w_dec, x1, y1;
  logic [IW-1:0] wm1, ev, ev_m1;
  logic          lb_en;
  logic [LW-1:0] lb_idx;
  logic [CW-1:0] lb_val;
  logic          col_skip;

  function automatic logic [MW-1:0] maddr(input logic [LW-1:0] a, input logic [LW-1:0] b,
                                          input logic [IW-1:0] i);
    return {a, b, i};
  endfunction

  cpoc_ram #(.DATA_W(CW), .ADDR_W(MW)) u_succ_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  cpoc_ram #(.DATA_W(CW), .ADDR_W(MW)) u_pred_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  assign len_sel     = len_q[len_idx];
  assign aft_idx     = (state_q == ST_PR_CHK || state_q == ST_PR_USE) ? om_q[LW-1:0]
                                                                       : ok_q[LW-1:0];
  assign bef_sel     = bef_q[ok_q[LW-1:0]];
  assign has_bef_sel = has_bef_q[ok_q[LW-1:0]];
  assign aft_sel     = aft_q[aft_idx];
  assign has_aft_sel = has_aft_q[aft_idx];
  assign fl_act      = AW'(fl_q) < active_q;
  assign tl_act      = AW'(tl_q) < active_q;
  assign f_ok        = fl_act && (CW'(fi_q) < len_f_q);
  assign t_ok        = tl_act && (CW'(ti_q) < len_sel);
  assign pm1         = p_rdata - CW'(1);
  assign w_dec       = w_q - CW'(1);
  assign wm1         = w_dec[IW-1:0];
  assign x1          = CW'(x_q) + CW'(1);
  assign y1          = CW'(y_q) + CW'(1);
  assign ev          = len_f_q[IW-1:0];
  assign ev_m1       = ev - IW'(1);
  assign col_skip    = (ok_q == AW'(fl_q)) || (ok_q == AW'(tl_q));

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    phase_d      = phase_q;
    fl_d         = fl_q;
    tl_d         = tl_q;
    fi_d         = fi_q;
    ti_d         = ti_q;
    to_at_d      = to_at_q;
    from_at_d    = from_at_q;
    len_f_d      = len_f_q;
    active_d     = active_q;
    len_d        = len_q;
    sb_d         = sb_q;
    has_bef_d    = has_bef_q;
    has_aft_d    = has_aft_q;
    bef_d        = bef_q;
    aft_d        = aft_q;
    ok_d         = ok_q;
    om_d         = om_q;
    ik_d         = ik_q;
    w_d          = w_q;
    p_d          = p_q;
    q_d          = q_q;
    x_d          = x_q;
    y_d          = y_q;
    res_status_d = res_status_q;
    res_fwd_d    = res_fwd_q;
    res_bwd_d    = res_bwd_q;
    res_safe_d   = res_safe_q;
    res_found_d  = res_found_q;
    res_cidx_d   = res_cidx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    fwd_d        = fwd_q;
    bwd_d        = bwd_q;
    safe_d       = safe_q;
    found_d      = found_q;
    cidx_d       = cidx_q;
    len_out_d    = len_out_q;
    s_we         = 1'b0;
    s_waddr      = '0;
    s_wdata      = '0;
    s_raddr      = '0;
    p_we         = 1'b0;
    p_waddr      = '0;
    p_wdata      = '0;
    p_raddr      = '0;
    lb_en        = 1'b0;
    lb_idx       = '0;
    lb_val       = '0;
    len_idx      = fl_q;
    in_ready_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        len_idx    = from_line_i;
        if (in_valid_i) begin
          op_d         = cpoc_pkg::opcode_e'(opcode_i);
          fl_d         = from_line_i;
          fi_d         = from_index_i;
          tl_d         = to_line_i;
          ti_d         = to_index_i;
          to_at_d      = to_is_atomic_write_i;
          from_at_d    = from_writes_atomically_i;
          len_f_d      = len_sel;
          res_status_d = 1'b0;
          res_fwd_d    = 1'b0;
          res_bwd_d    = 1'b0;
          res_safe_d   = 1'b0;
          res_found_d  = 1'b0;
          res_cidx_d   = '0;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        len_idx = tl_q;
        state_d = ST_DONE;
        case (op_q)
          cpoc_pkg::OP_ADD_LINE: begin
            if (active_q == AW'(NUM_LINES) || AW'(fl_q) != active_q) begin
              res_status_d = 1'b1;
            end else begin
              for (int j = 0; j < NUM_LINES; j++) begin
                sb_d[j] = '0;
              end
              ok_d    = '0;
              w_d     = '0;
              state_d = ST_SWEEP;
            end
          end
          cpoc_pkg::OP_APPEND: begin
            if (!fl_act || len_f_q == NONE_SUCC) begin
              res_status_d = 1'b1;
            end else begin
              len_d[fl_q] = len_f_q + CW'(1);
              ok_d        = '0;
              state_d     = ST_APP_RD;
            end
          end
          cpoc_pkg::OP_ADD_EDGE: begin
            if (!f_ok || !t_ok || fl_q == tl_q || (to_at_q && ti_q == '0)) begin
              res_status_d = 1'b1;
            end else begin
              if (to_at_q) begin
                ti_d = ti_q - IW'(1);
              end
              if (from_at_q && (CW'(fi_q) + CW'(1) < len_f_q)) begin
                fi_d = fi_q + IW'(1);
              end
              state_d = ST_QA;
            end
          end
          cpoc_pkg::OP_ORDER: begin
            if (!f_ok || !t_ok) begin
              res_status_d = 1'b1;
            end else if (fl_q == tl_q) begin
              res_fwd_d = fi_q < ti_q;
              res_bwd_d = ti_q < fi_q;
            end else begin
              state_d = ST_QA;
            end
          end
          cpoc_pkg::OP_SAFE: begin
            if (!f_ok) begin
              res_status_d = 1'b1;
            end else begin
              res_safe_d = CW'(fi_q) < sb_q[fl_q];
            end
          end
          cpoc_pkg::OP_SUCC, cpoc_pkg::OP_PRED: begin
            if (!f_ok || !tl_act || fl_q == tl_q) begin
              res_status_d = 1'b1;
            end else begin
              state_d = ST_QA;
            end
          end
          default: begin
            // inactive lines hold zero length and zero bound already
            for (int j = 0; j < NUM_LINES; j++) begin
              sb_d[j] = len_q[j];
            end
          end
        endcase
      end
      ST_SWEEP: begin
        len_idx = ok_q[LW-1:0];
        if (ok_q == active_q) begin
          active_d = active_q + AW'(1);
          state_d  = ST_DONE;
        end else if (w_q >= len_sel) begin
          ok_d = ok_q + AW'(1);
          w_d  = '0;
        end else begin
          s_we    = 1'b1;
          s_waddr = maddr(ok_q[LW-1:0], fl_q, w_q[IW-1:0]);
          s_wdata = NONE_SUCC;
          p_we    = 1'b1;
          p_waddr = maddr(ok_q[LW-1:0], fl_q, w_q[IW-1:0]);
          p_wdata = '0;
          w_d     = w_q + CW'(1);
        end
      end
      ST_APP_RD: begin
        if (ok_q == active_q) begin
          state_d = ST_DONE;
        end else if (ok_q == AW'(fl_q)) begin
          ok_d = ok_q + AW'(1);
        end else begin
          p_raddr = maddr(fl_q, ok_q[LW-1:0], ev_m1);
          state_d = ST_APP_USE;
        end
      end
      ST_APP_USE: begin
        s_we    = 1'b1;
        s_waddr = maddr(fl_q, ok_q[LW-1:0], ev);
        s_wdata = NONE_SUCC;
        p_we    = 1'b1;
        p_waddr = maddr(fl_q, ok_q[LW-1:0], ev);
        p_wdata = (len_f_q != '0) ? p_rdata : '0;
        lb_en   = 1'b1;
        lb_idx  = ok_q[LW-1:0];
        lb_val  = p_wdata;
        ok_d    = ok_q + AW'(1);
        state_d = ST_APP_RD;
      end
      ST_QA: begin
        s_raddr = maddr(fl_q, tl_q, fi_q);
        p_raddr = maddr(fl_q, tl_q, fi_q);
        state_d = ST_QB;
      end
      ST_QB: begin
        len_idx = tl_q;
        case (op_q)
          cpoc_pkg::OP_SUCC: begin
            if (s_rdata < len_sel) begin
              res_found_d = 1'b1;
              res_cidx_d  = s_rdata[IW-1:0];
            end
            state_d = ST_DONE;
          end
          cpoc_pkg::OP_PRED: begin
            if (p_rdata != '0) begin
              res_found_d = 1'b1;
              res_cidx_d  = pm1[IW-1:0];
            end
            state_d = ST_DONE;
          end
          default: begin
            res_fwd_d = s_rdata <= CW'(ti_q);
            s_raddr   = maddr(tl_q, fl_q, ti_q);
            state_d   = ST_QEVAL;
          end
        endcase
      end
      ST_QEVAL: begin
        res_bwd_d = s_rdata <= CW'(fi_q);
        state_d   = ST_DONE;
        if (op_q == cpoc_pkg::OP_ADD_EDGE) begin
          if (s_rdata <= CW'(fi_q)) begin
            res_status_d = 1'b1;
          end else if (!res_fwd_q) begin
            ok_d    = '0;
            state_d = ST_COL_RD;
          end
        end
      end
      ST_COL_RD: begin
        if (ok_q == active_q) begin
          p_d     = fl_q;
          x_d     = fi_q;
          q_d     = tl_q;
          y_d     = ti_q;
          phase_d = cpoc_pkg::PH_MAIN;
          ik_d    = '0;
          state_d = ST_IP_LB_RD;
        end else begin
          p_raddr = maddr(fl_q, ok_q[LW-1:0], fi_q);
          s_raddr = maddr(tl_q, ok_q[LW-1:0], ti_q);
          state_d = ST_COL_USE;
        end
      end
      ST_COL_USE: begin
        len_idx                   = ok_q[LW-1:0];
        has_bef_d[ok_q[LW-1:0]]   = !col_skip && (p_rdata != '0);
        bef_d[ok_q[LW-1:0]]       = pm1[IW-1:0];
        has_aft_d[ok_q[LW-1:0]]   = !col_skip && (s_rdata < len_sel);
        aft_d[ok_q[LW-1:0]]       = s_rdata[IW-1:0];
        ok_d                      = ok_q + AW'(1);
        state_d                   = ST_COL_RD;
      end
      ST_IP_LB_RD: begin
        if (ik_q == active_q) begin
          state_d = ST_IP_WR;
        end else begin
          p_raddr = maddr(q_q, ik_q[LW-1:0], y_q);
          state_d = ST_IP_LB_USE;
        end
      end
      ST_IP_LB_USE: begin
        lb_en   = 1'b1;
        lb_idx  = ik_q[LW-1:0];
        lb_val  = (ik_q == AW'(q_q)) ? CW'(y_q) : p_rdata;
        ik_d    = ik_q + AW'(1);
        state_d = ST_IP_LB_RD;
      end
      ST_IP_WR: begin
        s_we    = 1'b1;
        s_waddr = maddr(p_q, q_q, x_q);
        s_wdata = CW'(y_q);
        p_we    = 1'b1;
        p_waddr = maddr(q_q, p_q, y_q);
        p_wdata = x1;
        w_d     = CW'(x_q);
        state_d = ST_IP_SW_RD;
      end
      ST_IP_SW_RD: begin
        // successor walk goes down the source line
        if (w_q == '0) begin
          w_d     = y1;
          state_d = ST_IP_PW_RD;
        end else begin
          s_raddr = maddr(p_q, q_q, wm1);
          state_d = ST_IP_SW_USE;
        end
      end
      ST_IP_SW_USE: begin
        if (s_rdata <= CW'(y_q)) begin
          w_d     = y1;
          state_d = ST_IP_PW_RD;
        end else begin
          s_we    = 1'b1;
          s_waddr = maddr(p_q, q_q, wm1);
          s_wdata = CW'(y_q);
          w_d     = w_dec;
          state_d = ST_IP_SW_RD;
        end
      end
      ST_IP_PW_RD: begin
        // predecessor walk goes up the target line
        len_idx = q_q;
        if (w_q >= len_sel) begin
          state_d = ST_IP_RET;
        end else begin
          p_raddr = maddr(q_q, p_q, w_q[IW-1:0]);
          state_d = ST_IP_PW_USE;
        end
      end
      ST_IP_PW_USE: begin
        if (p_rdata >= x1) begin
          state_d = ST_IP_RET;
        end else begin
          p_we    = 1'b1;
          p_waddr = maddr(q_q, p_q, w_q[IW-1:0]);
          p_wdata = x1;
          w_d     = w_q + CW'(1);
          state_d = ST_IP_PW_RD;
        end
      end
      ST_IP_RET: begin
        case (phase_q)
          cpoc_pkg::PH_MAIN: begin
            ok_d    = '0;
            state_d = ST_BF_CHK;
          end
          cpoc_pkg::PH_BEF: begin
            ok_d    = ok_q + AW'(1);
            state_d = ST_BF_CHK;
          end
          cpoc_pkg::PH_AFT: begin
            ok_d    = ok_q + AW'(1);
            state_d = ST_AF_CHK;
          end
          default: begin
            om_d    = om_q + AW'(1);
            state_d = ST_PR_CHK;
          end
        endcase
      end
      ST_BF_CHK: begin
        if (ok_q == active_q) begin
          ok_d    = '0;
          state_d = ST_AF_CHK;
        end else if (!has_bef_sel) begin
          ok_d = ok_q + AW'(1);
        end else begin
          s_raddr = maddr(ok_q[LW-1:0], tl_q, bef_sel);
          state_d = ST_BF_USE;
        end
      end
      ST_BF_USE: begin
        if (s_rdata <= CW'(ti_q)) begin
          ok_d    = ok_q + AW'(1);
          state_d = ST_BF_CHK;
        end else begin
          p_d     = ok_q[LW-1:0];
          x_d     = bef_sel;
          q_d     = tl_q;
          y_d     = ti_q;
          phase_d = cpoc_pkg::PH_BEF;
          ik_d    = '0;
          state_d = ST_IP_LB_RD;
        end
      end
      ST_AF_CHK: begin
        if (ok_q == active_q) begin
          ok_d    = '0;
          om_d    = '0;
          state_d = ST_PR_CHK;
        end else if (!has_aft_sel) begin
          ok_d = ok_q + AW'(1);
        end else begin
          s_raddr = maddr(fl_q, ok_q[LW-1:0], fi_q);
          state_d = ST_AF_USE;
        end
      end
      ST_AF_USE: begin
        if (s_rdata <= CW'(aft_sel)) begin
          ok_d    = ok_q + AW'(1);
          state_d = ST_AF_CHK;
        end else begin
          p_d     = fl_q;
          x_d     = fi_q;
          q_d     = ok_q[LW-1:0];
          y_d     = aft_sel;
          phase_d = cpoc_pkg::PH_AFT;
          ik_d    = '0;
          state_d = ST_IP_LB_RD;
        end
      end
      ST_PR_CHK: begin
        if (ok_q == active_q) begin
          state_d = ST_DONE;
        end else if (!has_bef_sel || om_q == active_q) begin
          ok_d = ok_q + AW'(1);
          om_d = '0;
        end else if (!has_aft_sel || om_q == ok_q) begin
          om_d = om_q + AW'(1);
        end else begin
          s_raddr = maddr(ok_q[LW-1:0], om_q[LW-1:0], bef_sel);
          state_d = ST_PR_USE;
        end
      end
      ST_PR_USE: begin
        if (s_rdata <= CW'(aft_sel)) begin
          om_d    = om_q + AW'(1);
          state_d = ST_PR_CHK;
        end else begin
          p_d     = ok_q[LW-1:0];
          x_d     = bef_sel;
          q_d     = om_q[LW-1:0];
          y_d     = aft_sel;
          phase_d = cpoc_pkg::PH_PAIR;
          ik_d    = '0;
          state_d = ST_IP_LB_RD;
        end
      end
      ST_DONE: begin
        len_idx = fl_q;
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          fwd_d       = res_fwd_q;
          bwd_d       = res_bwd_q;
          safe_d      = res_safe_q;
          found_d     = res_found_q;
          cidx_d      = res_cidx_q;
          len_out_d   = fl_act ? len_sel : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // closure-safe bounds only ever shrink here
    for (int j = 0; j < NUM_LINES; j++) begin
      if (lb_en && lb_idx == LW'(j) && sb_q[j] > lb_val) begin
        sb_d[j] = lb_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < NUM_LINES; j++) begin
        len_q[j] <= '0;
        sb_q[j]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      len_q       <= len_d;
      sb_q        <= sb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    phase_q      <= phase_d;
    fl_q         <= fl_d;
    tl_q         <= tl_d;
    fi_q         <= fi_d;
    ti_q         <= ti_d;
    to_at_q      <= to_at_d;
    from_at_q    <= from_at_d;
    len_f_q      <= len_f_d;
    has_bef_q    <= has_bef_d;
    has_aft_q    <= has_aft_d;
    bef_q        <= bef_d;
    aft_q        <= aft_d;
    ok_q         <= ok_d;
    om_q         <= om_d;
    ik_q         <= ik_d;
    w_q          <= w_d;
    p_q          <= p_d;
    q_q          <= q_d;
    x_q          <= x_d;
    y_q          <= y_d;
    res_status_q <= res_status_d;
    res_fwd_q    <= res_fwd_d;
    res_bwd_q    <= res_bwd_d;
    res_safe_q   <= res_safe_d;
    res_found_q  <= res_found_d;
    res_cidx_q   <= res_cidx_d;
    status_q     <= status_d;
    fwd_q        <= fwd_d;
    bwd_q        <= bwd_d;
    safe_q       <= safe_d;
    found_q      <= found_d;
    cidx_q       <= cidx_d;
    len_out_q    <= len_out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign holds_forward_o  = fwd_q;
  assign holds_backward_o = bwd_q;
  assign is_safe_o        = safe_q;
  assign clock_found_o    = found_q;
  assign clock_index_o    = cidx_q;
  assign line_length_o    = len_out_q;

endmodule

@@ rtl/core/cpoc_checker.sv @@
// ----------------------------------------------------------------------------
// cpoc_checker
// port-level properties of the chain partial order closure block
// ----------------------------------------------------------------------------
module cpoc_checker #(
  parameter int NUM_LINES       = cpoc_pkg::NUM_LINES,
  parameter int EVENTS_PER_LINE = cpoc_pkg::EVENTS_PER_LINE,
  localparam int LW = $clog2(NUM_LINES),
  localparam int IW = $clog2(EVENTS_PER_LINE),
  localparam int CW = $clog2(EVENTS_PER_LINE + 1)
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic [2:0]    opcode_i,
  input logic [LW-1:0] from_line_i,
  input logic [IW-1:0] from_index_i,
  input logic [LW-1:0] to_line_i,
  input logic [IW-1:0] to_index_i,
  input logic          to_is_atomic_write_i,
  input logic          from_writes_atomically_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input logic          status_o,
  input logic          holds_forward_o,
  input logic          holds_backward_o,
  input logic          is_safe_o,
  input logic          clock_found_o,
  input logic [IW-1:0] clock_index_o,
  input logic [CW-1:0] line_length_o
);

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while the previous one is still in work");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(line_length_o) &&
       $stable(clock_index_o)))
    else $error("stalled result changed");

  a_index_without_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !clock_found_o) |-> (clock_index_o == '0))
    else $error("clock index set with no clock found");

  a_reject_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (!clock_found_o && !is_safe_o))
    else $error("rejected request reports a query answer");

  // the order stays acyclic
  a_no_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(holds_forward_o && holds_backward_o))
    else $error("events ordered both ways");

endmodule

bind chain_partial_order_closure cpoc_checker #(
  .NUM_LINES      (NUM_LINES),
  .EVENTS_PER_LINE(EVENTS_PER_LINE)
) u_cpoc_checker (.*);

@@ test/chain_partial_order_closure_tb.sv @@
// ----------------------------------------------------------------------------
// chain_partial_order_closure_tb
// checks the closure block against a cycle-free behavioral model of its state
// ----------------------------------------------------------------------------
// A directed opening covers every opcode and the rejection rules other than
// a full line set, a full line and a bad order query. Random requests
// follow: appends, edges and queries, mostly on existing events. Both
// channels stall at random. Each result is compared field by field with the
// model's prediction.
module chain_partial_order_closure_tb;
  import cpoc_pkg::*;

  localparam int NL = NUM_LINES;
  localparam int NE = EVENTS_PER_LINE;
  localparam int RANDOM_REQUESTS = 1100;
  localparam int HOLD_AT = 600;

  typedef struct packed {
    opcode_e    op;
    logic [2:0] fl;
    logic [5:0] fi;
    logic [2:0] tl;
    logic [5:0] ti;
    logic       ta;
    logic       fa;
  } request_t;

  typedef struct packed {
    logic       status;
    logic       fwd;
    logic       bwd;
    logic       safe;
    logic       found;
    logic [5:0] cidx;
    logic [6:0] len;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] opcode_i = '0;
  logic [2:0] from_line_i = '0;
  logic [5:0] from_index_i = '0;
  logic [2:0] to_line_i = '0;
  logic [5:0] to_index_i = '0;
  logic to_is_atomic_write_i = 1'b0;
  logic from_writes_atomically_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o, holds_forward_o, holds_backward_o, is_safe_o, clock_found_o;
  logic [5:0] clock_index_o;
  logic [6:0] line_length_o;

  chain_partial_order_closure dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .from_line_i,
    .from_index_i, .to_line_i, .to_index_i, .to_is_atomic_write_i,
    .from_writes_atomically_i, .out_valid_o, .out_ready_i, .status_o,
    .holds_forward_o, .holds_backward_o, .is_safe_o, .clock_found_o,
    .clock_index_o, .line_length_o
  );

  always #2 clk_i = ~clk_i;

  request_t pending_requests[$];
  outcome_t expected_results[$];
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int edge_count = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit holding = 1'b0;
  bit held_once = 1'b0;

  // model state
  int unsigned succ_q[NL][NL][NE];
  int unsigned pred_q[NL][NL][NE];
  int unsigned bound_q[NL];
  int unsigned length_q[NL];
  int unsigned live_lines = 0;

  // generator view of lines and lengths
  int unsigned gen_lines = 0;
  int unsigned gen_len[NL];

  function automatic bit event_exists(int unsigned l, int unsigned i);
    return l < live_lines && i < length_q[l];
  endfunction

  function automatic bit order_reaches(int unsigned fl, int unsigned fi,
                                       int unsigned tl, int unsigned ti);
    if (fl == tl) return fi < ti;
    return succ_q[fl][tl][fi] <= ti;
  endfunction

  function automatic void clamp_bound(int unsigned l, int unsigned v);
    if (bound_q[l] > v) bound_q[l] = v;
  endfunction

  function automatic void link_pair(int unsigned li, int unsigned a,
                                    int unsigned lj, int unsigned b);
    int unsigned k;
    for (k = 0; k < live_lines; k++) begin
      if (k == lj) clamp_bound(k, b);
      else clamp_bound(k, pred_q[lj][k][b]);
    end
    succ_q[li][lj][a] = b;
    pred_q[lj][li][b] = a + 1;
    for (k = a; k > 0; k--) begin
      if (succ_q[li][lj][k-1] <= b) break;
      succ_q[li][lj][k-1] = b;
    end
    for (k = b + 1; k < length_q[lj]; k++) begin
      if (pred_q[lj][li][k] >= a + 1) break;
      pred_q[lj][li][k] = a + 1;
    end
  endfunction

  function automatic void close_over_edge(int unsigned li, int unsigned a,
                                          int unsigned lj, int unsigned b);
    bit has_bef[NL];
    bit has_aft[NL];
    int unsigned bef[NL];
    int unsigned aft[NL];
    int unsigned k, m;
    for (k = 0; k < NL; k++) begin
      has_bef[k] = 0; has_aft[k] = 0; bef[k] = 0; aft[k] = 0;
    end
    for (k = 0; k < live_lines; k++) begin
      if (k == li || k == lj) continue;
      if (pred_q[li][k][a] != 0) begin
        has_bef[k] = 1; bef[k] = pred_q[li][k][a] - 1;
      end
      if (succ_q[lj][k][b] < length_q[k]) begin
        has_aft[k] = 1; aft[k] = succ_q[lj][k][b];
      end
    end
    link_pair(li, a, lj, b);
    for (k = 0; k < live_lines; k++)
      if (has_bef[k] && !order_reaches(k, bef[k], lj, b)) link_pair(k, bef[k], lj, b);
    for (k = 0; k < live_lines; k++)
      if (has_aft[k] && !order_reaches(li, a, k, aft[k])) link_pair(li, a, k, aft[k]);
    for (k = 0; k < live_lines; k++) begin
      if (!has_bef[k]) continue;
      for (m = 0; m < live_lines; m++)
        if (has_aft[m] && m != k && !order_reaches(k, bef[k], m, aft[m]))
          link_pair(k, bef[k], m, aft[m]);
    end
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int unsigned fl, fi, tl, ti, k, e;
    o = '0;
    fl = r.fl; fi = r.fi; tl = r.tl; ti = r.ti;
    case (r.op)
      OP_ADD_LINE: begin
        if (live_lines >= NL || fl != live_lines) o.status = 1;
        else begin
          for (k = 0; k < live_lines; k++) begin
            for (e = 0; e < length_q[k]; e++) begin
              succ_q[k][fl][e] = NE;
              pred_q[k][fl][e] = 0;
            end
            bound_q[k] = 0;
          end
          bound_q[fl] = 0;
          length_q[fl] = 0;
          live_lines++;
        end
      end
      OP_APPEND: begin
        if (fl >= live_lines || length_q[fl] >= NE) o.status = 1;
        else begin
          e = length_q[fl];
          length_q[fl] = e + 1;
          for (k = 0; k < live_lines; k++) begin
            if (k == fl) continue;
            succ_q[fl][k][e] = NE;
            pred_q[fl][k][e] = e > 0 ? pred_q[fl][k][e-1] : 0;
            clamp_bound(k, pred_q[fl][k][e]);
          end
        end
      end
      OP_ADD_EDGE: begin
        if (!event_exists(fl, fi) || !event_exists(tl, ti) || fl == tl) o.status = 1;
        else if (r.ta && ti == 0) o.status = 1;
        else begin
          if (r.ta) ti--;
          if (r.fa && fi + 1 < length_q[fl]) fi++;
          o.fwd = order_reaches(fl, fi, tl, ti);
          o.bwd = order_reaches(tl, ti, fl, fi);
          if (o.bwd) o.status = 1;
          else if (!o.fwd) close_over_edge(fl, fi, tl, ti);
        end
      end
      OP_ORDER: begin
        if (!event_exists(fl, fi) || !event_exists(tl, ti)) o.status = 1;
        else begin
          o.fwd = order_reaches(fl, fi, tl, ti);
          o.bwd = order_reaches(tl, ti, fl, fi);
        end
      end
      OP_SAFE: begin
        if (!event_exists(fl, fi)) o.status = 1;
        else o.safe = fi < bound_q[fl];
      end
      OP_SUCC, OP_PRED: begin
        if (!event_exists(fl, fi) || tl >= live_lines || tl == fl) o.status = 1;
        else if (r.op == OP_SUCC) begin
          if (succ_q[fl][tl][fi] < length_q[tl]) begin
            o.found = 1; o.cidx = succ_q[fl][tl][fi];
          end
        end else if (pred_q[fl][tl][fi] != 0) begin
          o.found = 1; o.cidx = pred_q[fl][tl][fi] - 1;
        end
      end
      default: begin
        for (k = 0; k < live_lines; k++) bound_q[k] = length_q[k];
      end
    endcase
    o.len = fl < live_lines ? length_q[fl] : 0;
    return o;
  endfunction

  function automatic void queue_request(opcode_e op, int fl, int fi, int tl, int ti,
                                        bit ta, bit fa);
    request_t r;
    r.op = op; r.fl = fl; r.fi = fi; r.tl = tl; r.ti = ti; r.ta = ta; r.fa = fa;
    if (op == OP_ADD_LINE && gen_lines < NL && fl == gen_lines) begin
      gen_len[fl] = 0;
      gen_lines++;
    end
    if (op == OP_APPEND && fl < gen_lines && gen_len[fl] < NE) gen_len[fl]++;
    pending_requests.push_back(r);
  endfunction

  // pick an existing event most of the time
  function automatic void pick_event(output int l, output int i);
    l = gen_lines > 0 ? $urandom_range(0, gen_lines - 1) : $urandom_range(0, 7);
    if (gen_lines > 0 && gen_len[l] > 0 && $urandom_range(0, 19) != 0)
      i = $urandom_range(0, gen_len[l] - 1);
    else i = $urandom_range(0, 63);
  endfunction

  function automatic int pick_gap(int phase);
    int p;
    if (phase % 3 == 0) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      error_count++;
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    request_t r;
    outcome_t o;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        r.op = opcode_e'(opcode_i); r.fl = from_line_i; r.fi = from_index_i;
        r.tl = to_line_i; r.ti = to_index_i; r.ta = to_is_atomic_write_i;
        r.fa = from_writes_atomically_i;
        o = apply_request(r);
        expected_results.push_back(o);
        if (r.op == OP_ADD_EDGE && !o.status) edge_count++;
        sent_count++;
        if (sent_count == HOLD_AT && !held_once) begin
          holding = 1'b1;
          held_once = 1'b1;
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (holding && expected_results.size() == 0) holding = 1'b0;
        if (holding) begin
          in_valid_i <= 1'b0;
        end else if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          r = pending_requests.pop_front();
          opcode_i <= r.op; from_line_i <= r.fl; from_index_i <= r.fi;
          to_line_i <= r.tl; to_index_i <= r.ti;
          to_is_atomic_write_i <= r.ta; from_writes_atomically_i <= r.fa;
          in_valid_i <= 1'b1;
          in_gap = pick_gap(sent_count / 100);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result with no request outstanding, status %0d", $time, status_o);
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, status_o);
          check_field("holds_forward", e.fwd, holds_forward_o);
          check_field("holds_backward", e.bwd, holds_backward_o);
          check_field("is_safe", e.safe, is_safe_o);
          check_field("clock_found", e.found, clock_found_o);
          check_field("clock_index", e.cidx, clock_index_o);
          check_field("line_length", e.len, line_length_o);
          checked_count++;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = pick_gap(checked_count / 80 + 1);
      end
    end
  end

  initial begin
    int n, p, fl, fi, tl, ti, k;
    for (k = 0; k < NL; k++) begin
      gen_len[k] = 0; bound_q[k] = 0; length_q[k] = 0;
    end
    // directed opening
    queue_request(OP_ADD_LINE, 0, 0, 0, 0, 0, 0);
    queue_request(OP_ADD_LINE, 2, 0, 0, 0, 0, 0);        // out of sequence
    queue_request(OP_ADD_LINE, 1, 0, 0, 0, 0, 0);
    for (k = 0; k < 3; k++) queue_request(OP_APPEND, 0, 0, 0, 0, 0, 0);
    for (k = 0; k < 3; k++) queue_request(OP_APPEND, 1, 0, 0, 0, 0, 0);
    queue_request(OP_APPEND, 5, 0, 0, 0, 0, 0);          // inactive line
    queue_request(OP_ADD_EDGE, 0, 1, 1, 0, 0, 0);
    queue_request(OP_ORDER, 0, 0, 1, 2, 0, 0);
    queue_request(OP_ORDER, 0, 2, 0, 1, 0, 0);           // same line
    queue_request(OP_ADD_EDGE, 1, 2, 0, 0, 0, 0);        // would close a cycle
    queue_request(OP_ADD_EDGE, 0, 0, 0, 2, 0, 0);        // same line
    queue_request(OP_ADD_EDGE, 1, 0, 0, 0, 1, 0);        // atomic write at zero
    queue_request(OP_ADD_EDGE, 0, 0, 1, 2, 1, 1);
    queue_request(OP_ADD_EDGE, 0, 1, 1, 1, 0, 0);        // already ordered
    queue_request(OP_ADD_EDGE, 0, 63, 1, 63, 0, 0);      // no such event
    queue_request(OP_ADD_LINE, 2, 0, 0, 0, 0, 0);
    queue_request(OP_APPEND, 2, 0, 0, 0, 0, 0);
    queue_request(OP_APPEND, 2, 0, 0, 0, 0, 0);
    queue_request(OP_ADD_EDGE, 2, 0, 0, 0, 0, 1);        // transitive closure
    queue_request(OP_SUCC, 2, 0, 1, 0, 0, 0);
    queue_request(OP_PRED, 1, 2, 2, 0, 0, 0);
    queue_request(OP_SUCC, 0, 0, 0, 0, 0, 0);            // same line
    queue_request(OP_PRED, 0, 0, 7, 0, 0, 0);            // inactive target
    queue_request(OP_SAFE, 0, 0, 0, 0, 0, 0);
    queue_request(OP_MARK_SAFE, 0, 0, 0, 0, 0, 0);
    queue_request(OP_SAFE, 0, 0, 0, 0, 0, 0);
    queue_request(OP_SAFE, 7, 63, 0, 0, 0, 0);
    // random part
    n = 0;
    while (n < RANDOM_REQUESTS) begin
      p = $urandom_range(0, 99);
      pick_event(fl, fi);
      pick_event(tl, ti);
      if (gen_lines > 1 && tl == fl && $urandom_range(0, 7) != 0)
        tl = (fl + $urandom_range(1, gen_lines - 1)) % gen_lines;
      if (p < 4 || gen_lines < 2) begin
        queue_request(OP_ADD_LINE, $urandom_range(0, 3) == 0 ? $urandom_range(0, 7)
                      : gen_lines, 0, 0, 0, 0, 0);
        n++;
      end else if (p < 6) begin
        // fill one line toward capacity
        for (k = 0; k < 30; k++) queue_request(OP_APPEND, fl, 0, 0, 0, 0, 0);
        n += 30;
      end else if (p < 22) begin
        queue_request(OP_APPEND, fl, $urandom_range(0, 63), $urandom_range(0, 7),
                      $urandom_range(0, 63), $urandom(), $urandom());
        n++;
      end else if (p < 55) begin
        queue_request(OP_ADD_EDGE, fl, fi, tl, ti, $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0);
        n++;
      end else if (p < 68) begin
        queue_request(OP_ORDER, fl, fi, tl, ti, 0, 0);
        n++;
      end else if (p < 74) begin
        queue_request(OP_SAFE, fl, fi, tl, ti, 0, 0);
        n++;
      end else if (p < 88) begin
        queue_request(p < 81 ? OP_SUCC : OP_PRED, fl, fi, tl, ti, 0, 0);
        n++;
      end else if (p < 91) begin
        queue_request(OP_MARK_SAFE, fl, fi, tl, ti, 0, 0);
        n++;
      end else begin
        queue_request(opcode_e'($urandom_range(0, 7)), $urandom_range(0, 7),
                      $urandom_range(0, 63), $urandom_range(0, 7), $urandom_range(0, 63),
                      $urandom(), $urandom());
        n++;
      end
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_requests.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d requests, %0d results checked, %0d edges inserted, %0d lines",
             sent_count, checked_count, edge_count, live_lines);
    if (error_count == 0 && expected_results.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
